@@ sv/breath_alarm_monitor_assert.svh @@
// ---------------------------------------------------------------------------
// Breath alarm monitor assertion macros
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BREATH_ALARM_MONITOR_ASSERT_SVH
`define BREATH_ALARM_MONITOR_ASSERT_SVH

// antecedent and consequent in the same cycle
`define BAM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define BAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bam_pkg.sv @@
// ---------------------------------------------------------------------------
// Breath alarm monitor package
// Widths, codes, limits and the window check shared by the block files.
// ---------------------------------------------------------------------------
package bam_pkg;

    // field widths
    localparam int FUNC_W     = 2;
    localparam int PRESS_W    = 8;
    localparam int VOL_W      = 12;
    localparam int LEAK_W     = 13;
    localparam int PCT_W      = 7;
    localparam int FLOW_W     = 8;
    localparam int ALARM_W    = 10;
    localparam int CNT_W      = 3;
    localparam int CHK_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_MEASURE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIP_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIP_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VT_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VT_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAK_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PEEP_SET   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIO2_SET   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TUBE_MODE  = 3'd7;

    // alarm bit positions
    localparam int BIT_HIPIP  = 0;
    localparam int BIT_LOPIP  = 1;
    localparam int BIT_HIPEEP = 2;
    localparam int BIT_LOPEEP = 3;
    localparam int BIT_HIVT   = 4;
    localparam int BIT_LOVT   = 5;
    localparam int BIT_HIFIO2 = 6;
    localparam int BIT_LOFIO2 = 7;
    localparam int BIT_O2SUP  = 8;
    localparam int BIT_LEAK   = 9;

    // limits
    localparam logic [CNT_W-1:0]   ARM_START   = 3'd5;
    localparam logic [CNT_W-1:0]   ARM_READY   = 3'd1;
    localparam logic [CNT_W-1:0]   ALERT_LIMIT = 3'd3;
    localparam logic [PRESS_W-1:0] PEEP_MARGIN = 8'd3;
    localparam logic [PCT_W-1:0]   FIO2_MARGIN = 7'd5;
    localparam logic [PCT_W-1:0]   FIO2_AIR    = 7'd21;
    localparam logic [FLOW_W-1:0]  FLOW_FAIL   = 8'd2;

    // reset values of the registers
    localparam logic [PRESS_W-1:0] PIP_MIN_RST   = 8'd0;
    localparam logic [PRESS_W-1:0] PIP_MAX_RST   = 8'd255;
    localparam logic [VOL_W-1:0]   VT_MIN_RST    = 12'd0;
    localparam logic [VOL_W-1:0]   VT_MAX_RST    = 12'd4095;
    localparam logic [VOL_W-1:0]   LEAK_LIM_RST  = 12'd4095;
    localparam logic [PRESS_W-1:0] PEEP_SET_RST  = 8'd5;
    localparam logic [PCT_W-1:0]   FIO2_SET_RST  = 7'd21;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             raise_hi;
        logic             raise_lo;
    } win_res_t;

    // one persistence step of a window channel; the fourth miss raises
    function automatic win_res_t win_check(input logic [CNT_W-1:0] cnt,
                                           input logic [CHK_W-1:0] v,
                                           input logic [CHK_W-1:0] lo,
                                           input logic [CHK_W-1:0] hi);
        win_res_t         res;
        logic [CNT_W-1:0] inc;
        res = '0;
        inc = cnt + 3'd1;
        if (v >= lo && v <= hi)
        begin
            res.cnt = '0;
        end
        else if (inc > ALERT_LIMIT)
        begin
            res.cnt      = '0;
            res.raise_lo = (v < lo);
            res.raise_hi = !(v < lo);
        end
        else
        begin
            res.cnt = inc;
        end
        return res;
    endfunction

endpackage

@@ sv/bam_if.sv @@
// ---------------------------------------------------------------------------
// Breath alarm monitor channels
// Valid/ready channels for measurement items and status items.
// ---------------------------------------------------------------------------
interface bam_meas_if;
    import bam_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [PRESS_W-1:0]       peak_pressure;
    logic [PRESS_W-1:0]       peep_average;
    logic [VOL_W-1:0]         tidal_volume;
    logic signed [LEAK_W-1:0] leak_volume;
    logic [PCT_W-1:0]         oxygen_achieved;
    logic [FLOW_W-1:0]        oxygen_flow_peak;

    modport source (output valid, func, peak_pressure, peep_average, tidal_volume,
                    leak_volume, oxygen_achieved, oxygen_flow_peak, input ready);
    modport sink (input valid, func, peak_pressure, peep_average, tidal_volume,
                  leak_volume, oxygen_achieved, oxygen_flow_peak, output ready);
endinterface

interface bam_status_if;
    import bam_pkg::*;

    logic               valid;
    logic               ready;
    logic [ALARM_W-1:0] alarm_bits;
    logic               alarm_seen;
    logic               armed;

    modport source (output valid, alarm_bits, alarm_seen, armed, input ready);
    modport sink (input valid, alarm_bits, alarm_seen, armed, output ready);
endinterface

@@ sv/breath_alarm_monitor.sv @@
// ---------------------------------------------------------------------------
// Breath alarm monitor
// Per-breath alarm checks with persistence counters on six channels.
// ---------------------------------------------------------------------------
//  channel   | dir | handshake   | payload
//  meas      | in  | valid/ready | func, pressures, volumes, oxygen, flow
//  status    | out | valid/ready | alarm_bits, alarm_seen, armed
//  cfg       | in  | cfg_we      | cfg_index, cfg_data (write only)
//
//  One item per cycle sustained unless status stalls (input register, result
//  register). All checks are single-level compares between the two.
//  Reset clears counters, flags and the handshake state; no clearing pass.
//  A stalled result holds in the result register while the item behind it
//  waits in the input register; meas.ready drops only when both are full.
// ---------------------------------------------------------------------------
module breath_alarm_monitor (
    input  logic                            clk,
    input  logic                            rst_n,
    bam_meas_if.sink                        meas,
    bam_status_if.source                    status,
    input  logic                            cfg_we,
    input  logic [bam_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bam_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bam_pkg::*;

    // configuration
    logic [PRESS_W-1:0] pip_min_reg;
    logic [PRESS_W-1:0] pip_max_reg;
    logic [VOL_W-1:0]   vt_min_reg;
    logic [VOL_W-1:0]   vt_max_reg;
    logic [VOL_W-1:0]   leak_limit_reg;
    logic [PRESS_W-1:0] peep_set_reg;
    logic [PCT_W-1:0]   fio2_set_reg;
    logic               tube_mode_reg;

    // input stage
    logic                     s1_valid_reg;
    logic [FUNC_W-1:0]        s1_func_reg;
    logic [PRESS_W-1:0]       s1_pip_reg;
    logic [PRESS_W-1:0]       s1_peep_reg;
    logic [VOL_W-1:0]         s1_vt_reg;
    logic signed [LEAK_W-1:0] s1_leak_reg;
    logic [PCT_W-1:0]         s1_o2_reg;
    logic [FLOW_W-1:0]        s1_flow_reg;

    // result stage
    logic               out_valid_reg;
    logic [ALARM_W-1:0] out_bits_reg;
    logic               out_seen_reg;
    logic               out_armed_reg;

    // channel state
    logic [CNT_W-1:0]   pip_count_reg, pip_count_next;
    logic [CNT_W-1:0]   peep_count_reg, peep_count_next;
    logic [CNT_W-1:0]   vt_count_reg, vt_count_next;
    logic [CNT_W-1:0]   supply_count_reg, supply_count_next;
    logic [CNT_W-1:0]   blend_count_reg, blend_count_next;
    logic [CNT_W-1:0]   leak_count_reg, leak_count_next;
    logic               supply_failed_reg, supply_failed_next;
    logic [ALARM_W-1:0] alarm_flags_reg, alarm_flags_next;
    logic [CNT_W-1:0]   arm_countdown_reg, arm_countdown_next;
    logic               alarm_latch_reg, alarm_latch_next;
    logic               armed_next;

    logic in_fire;
    logic advance;

    logic [CNT_W-1:0]   arm_dec;
    logic               chk_on;
    logic [PRESS_W-1:0] peep_lo;
    logic [PRESS_W:0]   peep_hi;
    logic [PCT_W-1:0]   fio2_lo;
    logic [PCT_W:0]     fio2_hi;
    logic               o2_on;
    logic               flow_low;
    logic [CNT_W-1:0]   supply_inc;
    logic               supply_trip;
    logic               failed_upd;
    logic               leak_hit;
    logic [CNT_W-1:0]   leak_inc;
    logic               leak_trip;
    win_res_t           pip_r, peep_r, vt_r, blend_r;

    assign advance    = !out_valid_reg || status.ready;
    assign meas.ready = !s1_valid_reg || advance;
    assign in_fire    = meas.valid && meas.ready;

    assign status.valid      = out_valid_reg;
    assign status.alarm_bits = out_bits_reg;
    assign status.alarm_seen = out_seen_reg;
    assign status.armed      = out_armed_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pip_min_reg    <= PIP_MIN_RST;
            pip_max_reg    <= PIP_MAX_RST;
            vt_min_reg     <= VT_MIN_RST;
            vt_max_reg     <= VT_MAX_RST;
            leak_limit_reg <= LEAK_LIM_RST;
            peep_set_reg   <= PEEP_SET_RST;
            fio2_set_reg   <= FIO2_SET_RST;
            tube_mode_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PIP_MIN:    pip_min_reg    <= cfg_data[PRESS_W-1:0];
                CFG_PIP_MAX:    pip_max_reg    <= cfg_data[PRESS_W-1:0];
                CFG_VT_MIN:     vt_min_reg     <= cfg_data[VOL_W-1:0];
                CFG_VT_MAX:     vt_max_reg     <= cfg_data[VOL_W-1:0];
                CFG_LEAK_LIMIT: leak_limit_reg <= cfg_data[VOL_W-1:0];
                CFG_PEEP_SET:   peep_set_reg   <= cfg_data[PRESS_W-1:0];
                CFG_FIO2_SET:   fio2_set_reg   <= cfg_data[PCT_W-1:0];
                CFG_TUBE_MODE:  tube_mode_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // ---------------- check logic ----------------
    assign arm_dec = (arm_countdown_reg > ARM_READY) ? arm_countdown_reg - 3'd1
                                                     : arm_countdown_reg;
    assign chk_on  = (arm_dec == ARM_READY);

    // low bounds saturate at zero
    assign peep_lo = (peep_set_reg < PEEP_MARGIN) ? '0 : peep_set_reg - PEEP_MARGIN;
    assign peep_hi = {1'b0, peep_set_reg} + {1'b0, PEEP_MARGIN};
    assign fio2_lo = (fio2_set_reg < FIO2_MARGIN) ? '0 : fio2_set_reg - FIO2_MARGIN;
    assign fio2_hi = {1'b0, fio2_set_reg} + {1'b0, FIO2_MARGIN};

    assign pip_r  = win_check(pip_count_reg, CHK_W'(s1_pip_reg),
                              CHK_W'(pip_min_reg), CHK_W'(pip_max_reg));
    assign peep_r = win_check(peep_count_reg, CHK_W'(s1_peep_reg),
                              CHK_W'(peep_lo), CHK_W'(peep_hi));
    assign vt_r   = win_check(vt_count_reg, CHK_W'(s1_vt_reg),
                              CHK_W'(vt_min_reg), CHK_W'(vt_max_reg));
    assign blend_r = win_check(blend_count_reg, CHK_W'(s1_o2_reg),
                               CHK_W'(fio2_lo), CHK_W'(fio2_hi));

    assign o2_on       = (fio2_set_reg > FIO2_AIR);
    assign flow_low    = (s1_flow_reg <= FLOW_FAIL);
    assign supply_inc  = supply_count_reg + 3'd1;
    assign supply_trip = (supply_inc > ALERT_LIMIT);
    // supply state as updated by this breath, gates the blend check
    assign failed_upd  = flow_low ? (supply_trip || supply_failed_reg) : 1'b0;

    assign leak_hit  = $signed({s1_leak_reg[LEAK_W-1], s1_leak_reg})
                       > $signed({2'b00, leak_limit_reg});
    assign leak_inc  = leak_count_reg + 3'd1;
    assign leak_trip = (leak_inc > ALERT_LIMIT);

    always_comb
    begin
        pip_count_next     = pip_count_reg;
        peep_count_next    = peep_count_reg;
        vt_count_next      = vt_count_reg;
        supply_count_next  = supply_count_reg;
        blend_count_next   = blend_count_reg;
        leak_count_next    = leak_count_reg;
        supply_failed_next = supply_failed_reg;
        alarm_flags_next   = alarm_flags_reg;
        arm_countdown_next = arm_countdown_reg;
        alarm_latch_next   = alarm_latch_reg;
        armed_next         = 1'b0;

        case (s1_func_reg)
            FUNC_CLEAR:
            begin
                alarm_flags_next = '0;
            end
            FUNC_RESTART:
            begin
                pip_count_next     = '0;
                peep_count_next    = '0;
                vt_count_next      = '0;
                supply_count_next  = '0;
                blend_count_next   = '0;
                leak_count_next    = '0;
                arm_countdown_next = ARM_START;
            end
            FUNC_MEASURE:
            begin
                arm_countdown_next = arm_dec;
                armed_next         = chk_on;
                if (chk_on)
                begin
                    pip_count_next  = pip_r.cnt;
                    peep_count_next = peep_r.cnt;
                    if (pip_r.raise_hi)
                    begin
                        alarm_flags_next[BIT_HIPIP] = 1'b1;
                        alarm_flags_next[BIT_LOPIP] = 1'b0;
                    end
                    if (pip_r.raise_lo)
                    begin
                        alarm_flags_next[BIT_LOPIP] = 1'b1;
                        alarm_flags_next[BIT_HIPIP] = 1'b0;
                    end
                    if (peep_r.raise_hi)
                    begin
                        alarm_flags_next[BIT_HIPEEP] = 1'b1;
                        alarm_flags_next[BIT_LOPEEP] = 1'b0;
                    end
                    if (peep_r.raise_lo)
                    begin
                        alarm_flags_next[BIT_LOPEEP] = 1'b1;
                        alarm_flags_next[BIT_HIPEEP] = 1'b0;
                    end
                    if (pip_r.raise_hi || pip_r.raise_lo || peep_r.raise_hi || peep_r.raise_lo)
                        alarm_latch_next = 1'b1;

                    if (tube_mode_reg)
                    begin
                        vt_count_next = vt_r.cnt;
                        if (vt_r.raise_hi)
                        begin
                            alarm_flags_next[BIT_HIVT] = 1'b1;
                            alarm_flags_next[BIT_LOVT] = 1'b0;
                        end
                        if (vt_r.raise_lo)
                        begin
                            alarm_flags_next[BIT_LOVT] = 1'b1;
                            alarm_flags_next[BIT_HIVT] = 1'b0;
                        end
                        if (vt_r.raise_hi || vt_r.raise_lo)
                            alarm_latch_next = 1'b1;

                        if (leak_hit)
                        begin
                            if (leak_trip)
                            begin
                                leak_count_next            = '0;
                                alarm_flags_next[BIT_LEAK] = 1'b1;
                                alarm_latch_next           = 1'b1;
                            end
                            else
                            begin
                                leak_count_next = leak_inc;
                            end
                        end
                        else
                        begin
                            leak_count_next = '0;
                        end
                    end

                    if (o2_on)
                    begin
                        supply_failed_next = failed_upd;
                        if (!flow_low)
                        begin
                            supply_count_next = '0;
                        end
                        else if (supply_trip)
                        begin
                            supply_count_next           = '0;
                            alarm_flags_next[BIT_O2SUP] = 1'b1;
                            alarm_latch_next            = 1'b1;
                        end
                        else
                        begin
                            supply_count_next = supply_inc;
                        end

                        // blending is not judged while the supply is down
                        if (!failed_upd)
                        begin
                            blend_count_next = blend_r.cnt;
                            if (blend_r.raise_hi)
                            begin
                                alarm_flags_next[BIT_HIFIO2] = 1'b1;
                                alarm_flags_next[BIT_LOFIO2] = 1'b0;
                            end
                            if (blend_r.raise_lo)
                            begin
                                alarm_flags_next[BIT_LOFIO2] = 1'b1;
                                alarm_flags_next[BIT_HIFIO2] = 1'b0;
                            end
                            if (blend_r.raise_hi || blend_r.raise_lo)
                                alarm_latch_next = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // ---------------- control and state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            pip_count_reg     <= '0;
            peep_count_reg    <= '0;
            vt_count_reg      <= '0;
            supply_count_reg  <= '0;
            blend_count_reg   <= '0;
            leak_count_reg    <= '0;
            supply_failed_reg <= 1'b0;
            alarm_flags_reg   <= '0;
            arm_countdown_reg <= ARM_START;
            alarm_latch_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= s1_valid_reg;

            if (advance && s1_valid_reg)
            begin
                pip_count_reg     <= pip_count_next;
                peep_count_reg    <= peep_count_next;
                vt_count_reg      <= vt_count_next;
                supply_count_reg  <= supply_count_next;
                blend_count_reg   <= blend_count_next;
                leak_count_reg    <= leak_count_next;
                supply_failed_reg <= supply_failed_next;
                alarm_flags_reg   <= alarm_flags_next;
                arm_countdown_reg <= arm_countdown_next;
                alarm_latch_reg   <= alarm_latch_next;
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_func_reg <= meas.func;
            s1_pip_reg  <= meas.peak_pressure;
            s1_peep_reg <= meas.peep_average;
            s1_vt_reg   <= meas.tidal_volume;
            s1_leak_reg <= meas.leak_volume;
            s1_o2_reg   <= meas.oxygen_achieved;
            s1_flow_reg <= meas.oxygen_flow_peak;
        end
        if (advance && s1_valid_reg)
        begin
            out_bits_reg  <= alarm_flags_next;
            out_seen_reg  <= alarm_latch_next;
            out_armed_reg <= armed_next;
        end
    end

endmodule

@@ sv/bam_checker.sv @@
// ---------------------------------------------------------------------------
// Breath alarm monitor checker
// Port-level properties of the status channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "breath_alarm_monitor_assert.svh"

module bam_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         status_valid,
    input logic                         status_ready,
    input logic [bam_pkg::ALARM_W-1:0]  status_alarm_bits,
    input logic                         status_alarm_seen,
    input logic                         status_armed
);
    import bam_pkg::*;

    // a stalled result keeps its item
    `BAM_ASSERT_NEXT(a_stall_hold, status_valid && !status_ready, status_valid && $stable(status_alarm_bits) && $stable(status_armed), "status item changed while stalled")

    // any raised bit implies the sticky flag
    `BAM_ASSERT_SAME(a_bits_seen, status_valid && (status_alarm_bits != '0), status_alarm_seen, "alarm bit without alarm_seen")

    // high and low of one channel never show together
    `BAM_ASSERT_SAME(a_pair_excl, status_valid, !(status_alarm_bits[BIT_HIPIP] && status_alarm_bits[BIT_LOPIP]) && !(status_alarm_bits[BIT_HIPEEP] && status_alarm_bits[BIT_LOPEEP]) && !(status_alarm_bits[BIT_HIVT] && status_alarm_bits[BIT_LOVT]) && !(status_alarm_bits[BIT_HIFIO2] && status_alarm_bits[BIT_LOFIO2]), "high and low alarm of one channel both set")

    // alarm_seen never falls from one shown item to the next
    `BAM_ASSERT_NEXT(a_seen_sticky, status_valid && status_alarm_seen, !status_valid || status_alarm_seen, "alarm_seen dropped")

endmodule

bind breath_alarm_monitor bam_checker u_bam_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .status_valid      (status.valid),
    .status_ready      (status.ready),
    .status_alarm_bits (status.alarm_bits),
    .status_alarm_seen (status.alarm_seen),
    .status_armed      (status.armed)
);
